// ===== design/dsi_pkg.sv =====
package dsi_pkg;

  // Wheel state codes
  typedef enum logic [1:0] {
    WS_OFF      = 2'd0,
    WS_NOTREADY = 2'd1,
    WS_READY    = 2'd2
  } wheel_state_t;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_DIST  = 3'd0,
    REG_MID_DIST  = 3'd1,
    REG_MAX_DIST  = 3'd2,
    REG_MIN_RATE  = 3'd3,
    REG_MID_RATE  = 3'd4,
    REG_MAX_RATE  = 3'd5,
    REG_SPIN_EN   = 3'd6
  } cfg_reg_t;

  // Reset values of the breakpoint registers
  localparam int MIN_DIST_RST = 768;
  localparam int MID_DIST_RST = 1536;
  localparam int MAX_DIST_RST = 2304;
  localparam int MIN_RATE_RST = 1900;
  localparam int MID_RATE_RST = 1800;
  localparam int MAX_RATE_RST = 1900;

  // Sideband that travels with each request down the pipeline
  typedef struct packed {
    logic         bypass;
    wheel_state_t state;
  } dsi_side_t;

endpackage

// ===== design/dsi_if.sv =====
interface dsi_in_if #(
  parameter int DIST_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic                 left_at_target;
  logic                 right_at_target;

  modport source (output valid, distance, left_at_target, right_at_target, input ready);
  modport sink   (input valid, distance, left_at_target, right_at_target, output ready);
endinterface

interface dsi_out_if #(
  parameter int RATE_BITS = 13
) ();
  logic                      valid;
  logic                      ready;
  logic signed [RATE_BITS:0] left_rate;
  logic signed [RATE_BITS:0] right_rate;
  logic [1:0]                wheel_state;

  modport source (output valid, left_rate, right_rate, wheel_state, input ready);
  modport sink   (input valid, left_rate, right_rate, wheel_state, output ready);
endinterface

// ===== design/dsi_front.sv =====
module dsi_front
  import dsi_pkg::*;
#(
  parameter int DIST_BITS = 16,
  parameter int RATE_BITS = 13
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [DIST_BITS-1:0]           distance,
  input  logic                           left_at_target,
  input  logic                           right_at_target,
  input  logic [DIST_BITS-1:0]           min_dist,
  input  logic [DIST_BITS-1:0]           mid_dist,
  input  logic [DIST_BITS-1:0]           max_dist,
  input  logic [RATE_BITS-1:0]           min_rate,
  input  logic [RATE_BITS-1:0]           mid_rate,
  input  logic [RATE_BITS-1:0]           max_rate,
  input  logic                           spin_enable,
  output logic                           f_valid,
  output dsi_side_t                      f_side,
  output logic [RATE_BITS-1:0]           f_byp_rate,
  output logic [DIST_BITS+RATE_BITS-1:0] f_num,
  output logic [DIST_BITS-1:0]           f_span
);

  localparam int NUM_BITS = DIST_BITS + RATE_BITS;

  // Stage one: segment selection
  dsi_side_t            side_nxt;
  logic [RATE_BITS-1:0] byp_rate_nxt;
  logic [DIST_BITS-1:0] close_pt;
  logic [DIST_BITS-1:0] far_pt;
  logic [RATE_BITS-1:0] close_rt;
  logic [RATE_BITS-1:0] far_rt;
  logic                 upper;

  logic                 s1_valid_r;
  dsi_side_t            s1_side_r;
  logic [RATE_BITS-1:0] s1_byp_rate_r;
  logic [DIST_BITS-1:0] s1_dlo_r;
  logic [DIST_BITS-1:0] s1_dhi_r;
  logic [RATE_BITS-1:0] s1_close_rt_r;
  logic [RATE_BITS-1:0] s1_far_rt_r;
  logic [DIST_BITS-1:0] s1_span_r;

  logic                 s2_valid_r;
  dsi_side_t            s2_side_r;
  logic [RATE_BITS-1:0] s2_byp_rate_r;
  logic [NUM_BITS-1:0]  s2_p0_r;
  logic [NUM_BITS-1:0]  s2_p1_r;
  logic [DIST_BITS-1:0] s2_span_r;

  logic                 s3_valid_r;
  dsi_side_t            s3_side_r;
  logic [RATE_BITS-1:0] s3_byp_rate_r;
  logic [NUM_BITS-1:0]  s3_num_r;
  logic [DIST_BITS-1:0] s3_span_r;

  assign upper    = (distance >= mid_dist);
  assign close_pt = upper ? mid_dist : min_dist;
  assign far_pt   = upper ? max_dist : mid_dist;
  assign close_rt = upper ? mid_rate : min_rate;
  assign far_rt   = upper ? max_rate : mid_rate;

  // Pick the clamp, the zero rate, the close rate of an empty segment or the segment to interpolate
  always_comb begin
    side_nxt.bypass = 1'b1;
    side_nxt.state  = WS_OFF;
    byp_rate_nxt    = '0;
    if (spin_enable) begin
      side_nxt.state = (left_at_target && right_at_target) ? WS_READY : WS_NOTREADY;
      if (distance >= max_dist) begin
        byp_rate_nxt = max_rate;
      end else if (distance <= min_dist) begin
        byp_rate_nxt = min_rate;
      end else if (far_pt <= close_pt || distance < close_pt || distance > far_pt) begin
        // empty or reversed segment gives the close rate
        byp_rate_nxt = close_rt;
      end else begin
        side_nxt.bypass = 1'b0;
      end
    end
  end

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Advance the payload: select, multiply, sum
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r     <= side_nxt;
      s1_byp_rate_r <= byp_rate_nxt;
      s1_dlo_r      <= distance - close_pt;
      s1_dhi_r      <= far_pt - distance;
      s1_close_rt_r <= close_rt;
      s1_far_rt_r   <= far_rt;
      s1_span_r     <= far_pt - close_pt;

      s2_side_r     <= s1_side_r;
      s2_byp_rate_r <= s1_byp_rate_r;
      s2_p0_r       <= NUM_BITS'(s1_dlo_r) * NUM_BITS'(s1_far_rt_r);
      s2_p1_r       <= NUM_BITS'(s1_dhi_r) * NUM_BITS'(s1_close_rt_r);
      s2_span_r     <= s1_span_r;

      // sum stays at most span times the larger rate
      s3_side_r     <= s2_side_r;
      s3_byp_rate_r <= s2_byp_rate_r;
      s3_num_r      <= s2_p0_r + s2_p1_r;
      s3_span_r     <= s2_span_r;
    end
  end

  assign f_valid    = s3_valid_r;
  assign f_side     = s3_side_r;
  assign f_byp_rate = s3_byp_rate_r;
  assign f_num      = s3_num_r;
  assign f_span     = s3_span_r;

endmodule

// ===== design/dsi_div_cell.sv =====
module dsi_div_cell
  import dsi_pkg::*;
#(
  parameter int DIST_BITS = 16,
  parameter int RATE_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 i_valid,
  input  dsi_side_t            i_side,
  input  logic [DIST_BITS-1:0] i_rem,
  input  logic [RATE_BITS-1:0] i_low,
  input  logic [RATE_BITS-1:0] i_quot,
  input  logic [DIST_BITS-1:0] i_span,
  output logic                 o_valid,
  output dsi_side_t            o_side,
  output logic [DIST_BITS-1:0] o_rem,
  output logic [RATE_BITS-1:0] o_low,
  output logic [RATE_BITS-1:0] o_quot,
  output logic [DIST_BITS-1:0] o_span
);

  logic [DIST_BITS:0]   rem_sh;
  logic [DIST_BITS:0]   rem_sub;
  logic                 q_bit;
  logic [DIST_BITS-1:0] rem_nxt;
  logic [RATE_BITS-1:0] quot_nxt;

  logic                 valid_r;
  dsi_side_t            side_r;
  logic [DIST_BITS-1:0] rem_r;
  logic [RATE_BITS-1:0] low_r;
  logic [RATE_BITS-1:0] quot_r;
  logic [DIST_BITS-1:0] span_r;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  assign rem_sh   = {i_rem, i_low[RATE_BITS-1]};
  assign rem_sub  = rem_sh - {1'b0, i_span};
  assign q_bit    = (rem_sh >= {1'b0, i_span});
  assign rem_nxt  = q_bit ? rem_sub[DIST_BITS-1:0] : rem_sh[DIST_BITS-1:0];
  // a bypassed request keeps its rate untouched
  assign quot_nxt = i_side.bypass ? i_quot : {i_quot[RATE_BITS-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= i_side;
      rem_r  <= rem_nxt;
      low_r  <= {i_low[RATE_BITS-2:0], 1'b0};
      quot_r <= quot_nxt;
      span_r <= i_span;
    end
  end

  assign o_valid = valid_r;
  assign o_side  = side_r;
  assign o_rem   = rem_r;
  assign o_low   = low_r;
  assign o_quot  = quot_r;
  assign o_span  = span_r;

endmodule

// ===== design/distance_to_speed_interpolator_top.sv =====
// A taken request passes through select, multiply, sum, one divider cell per quotient bit
// and the output register, in that order.
// Throughput: one request per cycle; the whole pipeline holds when the output
// register is full and not taken.
// Reset: synchronous active-low rst_n empties the pipeline and loads register defaults.
module distance_to_speed_interpolator_top
  import dsi_pkg::*;
#(
  parameter int DIST_BITS = 16,
  parameter int RATE_BITS = 13,
  localparam int CfgW = (DIST_BITS > RATE_BITS) ? DIST_BITS : RATE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  dsi_in_if.sink                  in_ch,
  dsi_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CfgW-1:0]         cfg_wdata
);

  localparam int NUM_BITS = DIST_BITS + RATE_BITS;

  logic [DIST_BITS-1:0] min_dist_r;
  logic [DIST_BITS-1:0] mid_dist_r;
  logic [DIST_BITS-1:0] max_dist_r;
  logic [RATE_BITS-1:0] min_rate_r;
  logic [RATE_BITS-1:0] mid_rate_r;
  logic [RATE_BITS-1:0] max_rate_r;
  logic                 spin_en_r;

  logic                 adv;
  logic                 f_valid;
  dsi_side_t            f_side;
  logic [RATE_BITS-1:0] f_byp_rate;
  logic [NUM_BITS-1:0]  f_num;
  logic [DIST_BITS-1:0] f_span;

  logic                 c_valid [RATE_BITS+1];
  dsi_side_t            c_side  [RATE_BITS+1];
  logic [DIST_BITS-1:0] c_rem   [RATE_BITS+1];
  logic [RATE_BITS-1:0] c_low   [RATE_BITS+1];
  logic [RATE_BITS-1:0] c_quot  [RATE_BITS+1];
  logic [DIST_BITS-1:0] c_span  [RATE_BITS+1];

  logic                      out_valid_r;
  logic signed [RATE_BITS:0] left_rate_r;
  logic signed [RATE_BITS:0] right_rate_r;
  wheel_state_t              wheel_state_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= DIST_BITS'(MIN_DIST_RST);
      mid_dist_r <= DIST_BITS'(MID_DIST_RST);
      max_dist_r <= DIST_BITS'(MAX_DIST_RST);
      min_rate_r <= RATE_BITS'(MIN_RATE_RST);
      mid_rate_r <= RATE_BITS'(MID_RATE_RST);
      max_rate_r <= RATE_BITS'(MAX_RATE_RST);
      spin_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DIST: min_dist_r <= cfg_wdata[DIST_BITS-1:0];
        REG_MID_DIST: mid_dist_r <= cfg_wdata[DIST_BITS-1:0];
        REG_MAX_DIST: max_dist_r <= cfg_wdata[DIST_BITS-1:0];
        REG_MIN_RATE: min_rate_r <= cfg_wdata[RATE_BITS-1:0];
        REG_MID_RATE: mid_rate_r <= cfg_wdata[RATE_BITS-1:0];
        REG_MAX_RATE: max_rate_r <= cfg_wdata[RATE_BITS-1:0];
        REG_SPIN_EN:  spin_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance everything whenever the output register is free or being taken
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  dsi_front #(
    .DIST_BITS (DIST_BITS),
    .RATE_BITS (RATE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_ch.valid),
    .distance        (in_ch.distance),
    .left_at_target  (in_ch.left_at_target),
    .right_at_target (in_ch.right_at_target),
    .min_dist        (min_dist_r),
    .mid_dist        (mid_dist_r),
    .max_dist        (max_dist_r),
    .min_rate        (min_rate_r),
    .mid_rate        (mid_rate_r),
    .max_rate        (max_rate_r),
    .spin_enable     (spin_en_r),
    .f_valid         (f_valid),
    .f_side          (f_side),
    .f_byp_rate      (f_byp_rate),
    .f_num           (f_num),
    .f_span          (f_span)
  );

  // Seed the divider chain; the top numerator bits are already below the span
  assign c_valid[0] = f_valid;
  assign c_side[0]  = f_side;
  assign c_rem[0]   = f_num[NUM_BITS-1:RATE_BITS];
  assign c_low[0]   = f_num[RATE_BITS-1:0];
  assign c_quot[0]  = f_side.bypass ? f_byp_rate : '0;
  assign c_span[0]  = f_span;

  for (genvar g = 0; g < RATE_BITS; g++) begin : g_cell
    dsi_div_cell #(
      .DIST_BITS (DIST_BITS),
      .RATE_BITS (RATE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .i_valid (c_valid[g]),
      .i_side  (c_side[g]),
      .i_rem   (c_rem[g]),
      .i_low   (c_low[g]),
      .i_quot  (c_quot[g]),
      .i_span  (c_span[g]),
      .o_valid (c_valid[g+1]),
      .o_side  (c_side[g+1]),
      .o_rem   (c_rem[g+1]),
      .o_low   (c_low[g+1]),
      .o_quot  (c_quot[g+1]),
      .o_span  (c_span[g+1])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid[RATE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      right_rate_r  <= $signed({1'b0, c_quot[RATE_BITS]});
      left_rate_r   <= -$signed({1'b0, c_quot[RATE_BITS]});
      wheel_state_r <= c_side[RATE_BITS].state;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_rate   = left_rate_r;
  assign out_ch.right_rate  = right_rate_r;
  assign out_ch.wheel_state = wheel_state_r;

endmodule
